FILE: src/cmbm_pkg.sv
package cmbm_pkg;

    // Opcodes handled by the unit
    localparam logic [7:0] OP_XBA = 8'hEB;
    localparam logic [7:0] OP_STP = 8'hDB;
    localparam logic [7:0] OP_WAI = 8'hCB;
    localparam logic [7:0] OP_WDM = 8'h42;
    localparam logic [7:0] OP_NOP = 8'hEA;
    localparam logic [7:0] OP_MVP = 8'h44;
    localparam logic [7:0] OP_MVN = 8'h54;

    localparam logic [15:0] COUNT_END = 16'hFFFF;
    localparam logic [18:0] CYC_PER_BYTE = 19'd7;
    localparam logic [1:0] PC_MOVE = 2'd3;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW = $clog2(CMD_DEPTH);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW = $clog2(OUT_DEPTH);

    localparam logic ITEM_EXEC = 1'b0;
    localparam logic ITEM_DATA = 1'b1;

    typedef enum logic [1:0] {
        RES_DONE  = 2'd0,
        RES_READ  = 2'd1,
        RES_WRITE = 2'd2
    } t_res_kind;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_FLAGS   = 3'd1,
        ST_WAIT    = 3'd2,
        ST_STOP    = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CMD_DATA = 2'd0,
        CMD_DONE = 2'd1,
        CMD_MOVE = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  opcode;
        logic [7:0]  dest_bank_operand;
        logic [7:0]  source_bank_operand;
        logic [15:0] acc_in;
        logic [15:0] x_in;
        logic [15:0] y_in;
        logic [7:0]  read_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [23:0] bus_address;
        logic [7:0]  write_data;
        logic [15:0] acc_out;
        logic [15:0] x_out;
        logic [15:0] y_out;
        logic [7:0]  data_bank_out;
        logic [1:0]  pc_advance;
        logic [18:0] cycles_added;
        logic [1:0]  flags_nz;
        logic [2:0]  status;
        logic        last;
    } t_out_item;

    // Classified item passed from front to back
    typedef struct packed {
        t_cmd_kind   kind;
        logic        descending;
        logic [15:0] acc;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  dbank;
        logic [7:0]  sbank;
        logic [7:0]  data;
        logic [1:0]  pc;
        logic [1:0]  cyc;
        logic [1:0]  nz;
        t_status     status;
    } t_cmd;

endpackage

FILE: src/cmbm_front.sv
module cmbm_front (
    input  cmbm_pkg::t_in_item i_item,
    output cmbm_pkg::t_cmd     o_cmd
);

    logic [7:0] w_hi;

    assign w_hi = i_item.acc_in[15:8];

    always_comb begin
        o_cmd            = '0;
        o_cmd.kind       = cmbm_pkg::CMD_DONE;
        o_cmd.acc        = i_item.acc_in;
        o_cmd.x          = i_item.x_in;
        o_cmd.y          = i_item.y_in;
        o_cmd.sbank      = i_item.source_bank_operand;
        o_cmd.data       = i_item.read_data;
        o_cmd.status     = cmbm_pkg::ST_DONE;
        if (i_item.item_kind == cmbm_pkg::ITEM_DATA) begin
            o_cmd.kind = cmbm_pkg::CMD_DATA;
        end else begin
            case (i_item.opcode)
                cmbm_pkg::OP_XBA: begin
                    o_cmd.acc    = {i_item.acc_in[7:0], w_hi};
                    o_cmd.nz     = {w_hi[7], (w_hi == 8'h00)};
                    o_cmd.pc     = 2'd1;
                    o_cmd.cyc    = 2'd3;
                    o_cmd.status = cmbm_pkg::ST_FLAGS;
                end
                cmbm_pkg::OP_STP: begin
                    o_cmd.pc     = 2'd1;
                    o_cmd.cyc    = 2'd3;
                    o_cmd.status = cmbm_pkg::ST_STOP;
                end
                cmbm_pkg::OP_WAI: begin
                    o_cmd.pc     = 2'd1;
                    o_cmd.cyc    = 2'd3;
                    o_cmd.status = cmbm_pkg::ST_WAIT;
                end
                cmbm_pkg::OP_WDM: begin
                    o_cmd.pc  = 2'd2;
                    o_cmd.cyc = 2'd2;
                end
                cmbm_pkg::OP_NOP: begin
                    o_cmd.pc  = 2'd1;
                    o_cmd.cyc = 2'd2;
                end
                cmbm_pkg::OP_MVP, cmbm_pkg::OP_MVN: begin
                    o_cmd.dbank      = i_item.dest_bank_operand;
                    o_cmd.descending = (i_item.opcode == cmbm_pkg::OP_MVP);
                    if (i_item.acc_in == cmbm_pkg::COUNT_END) begin
                        // nothing to move: report at once
                        o_cmd.pc = cmbm_pkg::PC_MOVE;
                    end else begin
                        o_cmd.kind = cmbm_pkg::CMD_MOVE;
                    end
                end
                default: begin
                    o_cmd.status = cmbm_pkg::ST_UNKNOWN;
                end
            endcase
        end
    end

endmodule

FILE: src/cmbm_cmd_fifo.sv
module cmbm_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  cmbm_pkg::t_cmd i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output cmbm_pkg::t_cmd o_rdata
);

    cmbm_pkg::t_cmd                r_mem [cmbm_pkg::CMD_DEPTH];
    logic [cmbm_pkg::CMD_AW-1:0]   r_wp;
    logic [cmbm_pkg::CMD_AW-1:0]   r_rp;
    logic [cmbm_pkg::CMD_AW:0]     r_cnt;
    logic                          w_wr;
    logic                          w_rd;

    assign o_full  = (r_cnt == (cmbm_pkg::CMD_AW+1)'(cmbm_pkg::CMD_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{cmbm_pkg::CMD_AW{1'b0}}, w_wr}
                           - {{cmbm_pkg::CMD_AW{1'b0}}, w_rd};
        end
    end

endmodule

FILE: src/cmbm_back.sv
module cmbm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  cmbm_pkg::t_cmd      i_cmd,
    output logic                o_cmd_take,
    input  logic                pop,
    output logic                empty,
    output cmbm_pkg::t_out_item o_res
);

    // move state
    logic        r_active;
    logic        r_desc;
    logic [15:0] r_count;
    logic [15:0] r_src;
    logic [15:0] r_dst;
    logic [7:0]  r_sbank;
    logic [7:0]  r_dbank;
    logic [18:0] r_total;

    logic [15:0] n_src;
    logic [15:0] n_dst;
    logic [15:0] n_count;
    logic [18:0] n_total;

    // result queue
    cmbm_pkg::t_out_item         r_q [cmbm_pkg::OUT_DEPTH];
    logic [cmbm_pkg::OUT_AW-1:0] r_wp;
    logic [cmbm_pkg::OUT_AW-1:0] r_rp;
    logic [cmbm_pkg::OUT_AW:0]   r_cnt;

    cmbm_pkg::t_out_item w_res0;
    cmbm_pkg::t_out_item w_res1;
    logic [1:0]          w_nres;
    logic                w_pop;

    assign empty      = (r_cnt == '0);
    assign o_res      = r_q[r_rp];
    assign w_pop      = pop && !empty;
    // take a command only when two result slots are free
    assign o_cmd_take = i_cmd_valid &&
        (r_cnt <= (cmbm_pkg::OUT_AW+1)'(cmbm_pkg::OUT_DEPTH - 2));

    assign n_src   = r_desc ? r_src - 16'd1 : r_src + 16'd1;
    assign n_dst   = r_desc ? r_dst - 16'd1 : r_dst + 16'd1;
    assign n_count = r_count - 16'd1;
    assign n_total = r_total + cmbm_pkg::CYC_PER_BYTE;

    always_comb begin
        w_res0 = '0;
        w_res1 = '0;
        w_nres = 2'd0;
        case (i_cmd.kind)
            cmbm_pkg::CMD_DATA: begin
                if (r_active) begin
                    w_res0.result_kind = cmbm_pkg::RES_WRITE;
                    w_res0.bus_address = {r_dbank, r_dst};
                    w_res0.write_data  = i_cmd.data;
                    if (n_count == cmbm_pkg::COUNT_END) begin
                        w_res1.result_kind   = cmbm_pkg::RES_DONE;
                        w_res1.acc_out       = n_count;
                        w_res1.x_out         = n_src;
                        w_res1.y_out         = n_dst;
                        w_res1.data_bank_out = r_dbank;
                        w_res1.pc_advance    = cmbm_pkg::PC_MOVE;
                        w_res1.cycles_added  = n_total;
                        w_res1.status        = cmbm_pkg::ST_DONE;
                    end else begin
                        w_res1.result_kind = cmbm_pkg::RES_READ;
                        w_res1.bus_address = {r_sbank, n_src};
                    end
                    w_res1.last = 1'b1;
                    w_nres      = 2'd2;
                end
            end
            cmbm_pkg::CMD_MOVE: begin
                w_res0.result_kind = cmbm_pkg::RES_READ;
                w_res0.bus_address = {i_cmd.sbank, i_cmd.x};
                w_res0.last        = 1'b1;
                w_nres             = 2'd1;
            end
            cmbm_pkg::CMD_DONE: begin
                w_res0.result_kind   = cmbm_pkg::RES_DONE;
                w_res0.acc_out       = i_cmd.acc;
                w_res0.x_out         = i_cmd.x;
                w_res0.y_out         = i_cmd.y;
                w_res0.data_bank_out = i_cmd.dbank;
                w_res0.pc_advance    = i_cmd.pc;
                w_res0.cycles_added  = {17'd0, i_cmd.cyc};
                w_res0.flags_nz      = i_cmd.nz;
                w_res0.status        = i_cmd.status;
                w_res0.last          = 1'b1;
                w_nres               = 2'd1;
            end
            default: begin
                w_nres = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take && (w_nres != 2'd0)) begin
            r_q[r_wp] <= w_res0;
        end
        if (o_cmd_take && (w_nres == 2'd2)) begin
            r_q[r_wp + 1'b1] <= w_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (o_cmd_take) begin
                r_wp <= r_wp + w_nres[cmbm_pkg::OUT_AW-1:0];
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt
                   + (o_cmd_take ? (cmbm_pkg::OUT_AW+1)'(w_nres) : '0)
                   - {{cmbm_pkg::OUT_AW{1'b0}}, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_desc   <= 1'b0;
            r_count  <= '0;
            r_src    <= '0;
            r_dst    <= '0;
            r_sbank  <= '0;
            r_dbank  <= '0;
            r_total  <= '0;
        end else if (o_cmd_take) begin
            case (i_cmd.kind)
                cmbm_pkg::CMD_DATA: begin
                    if (r_active) begin
                        r_src    <= n_src;
                        r_dst    <= n_dst;
                        r_count  <= n_count;
                        r_total  <= n_total;
                        r_active <= (n_count != cmbm_pkg::COUNT_END);
                    end
                end
                cmbm_pkg::CMD_MOVE: begin
                    r_active <= 1'b1;
                    r_desc   <= i_cmd.descending;
                    r_count  <= i_cmd.acc;
                    r_src    <= i_cmd.x;
                    r_dst    <= i_cmd.y;
                    r_sbank  <= i_cmd.sbank;
                    r_dbank  <= i_cmd.dbank;
                    r_total  <= '0;
                end
                default: begin
                    // any other instruction abandons a pending move
                    r_active <= 1'b0;
                end
            endcase
        end
    end

endmodule

FILE: src/cpu_misc_ops_block_move_top.sv
// Results are registered: a pushed item is written into the command queue, and when the back
// takes the command it writes its results into the result queue, which drives the result ports.
// Intake takes one item per cycle while full is low, and the back takes a command only when
// two result slots are free; a returned byte of a move gives two results (write request and
// then read request or done), so such items drain at the pace of the single result port.
// Reset (synchronous, active low) empties both queues and drops any pending move.
module cpu_misc_ops_block_move_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input side
    input  logic                push,
    input  cmbm_pkg::t_in_item  i_item,
    output logic                full,
    // result side
    input  logic                pop,
    output logic                empty,
    output cmbm_pkg::t_out_item o_res
);

    cmbm_pkg::t_cmd w_dec_cmd;
    cmbm_pkg::t_cmd w_head_cmd;
    logic           w_head_valid;
    logic           w_cmd_take;

    // Front: classify each item into a done report, a move start or move data.
    cmbm_front u_front (
        .i_item (i_item),
        .o_cmd  (w_dec_cmd)
    );

    // Command queue: decouple intake from execution so each side can stall.
    cmbm_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (w_dec_cmd),
        .o_full  (full),
        .i_rd    (w_cmd_take),
        .o_valid (w_head_valid),
        .o_rdata (w_head_cmd)
    );

    // Back: hold the move state, build requests and done reports, and queue
    // them for transfer on the result side.
    cmbm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_head_valid),
        .i_cmd       (w_head_cmd),
        .o_cmd_take  (w_cmd_take),
        .pop         (pop),
        .empty       (empty),
        .o_res       (o_res)
    );

endmodule
